// ===== hw/rtl/text_mode_console_writer_macros.svh =====
// Assertion macros for the text mode console writer.
// Define ASSERT_OFF to compile every check away.
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define TMCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define TMCW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TMCW_ASSERT(lbl, clk, rst_n, prop, msg)

`define TMCW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/tmcw_pkg.sv =====
// Shared constants, codes, structs and the cell address function of the
// text mode console writer. No dependencies.
package tmcw_pkg;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int TAB_WIDTH_DEF = 8;
	localparam int CELL_COUNT    = COLUMNS * ROWS;

	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int ADDR_W  = $clog2(CELL_COUNT);
	localparam int CELL_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int ACT_W   = 2;
	localparam int COLOR_W = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COLOR_W;

	localparam int IN_FIELDS_W  = CHAR_W + ADDR_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = ADDR_W + COL_W + ROW_W + CELL_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

	localparam logic [CHAR_W-1:0]  BLANK_CHAR = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_FG   = 4'hF;
	localparam logic [COLOR_W-1:0] RESET_BG   = 4'h0;
	localparam logic [CELL_W-1:0]  RESET_CELL = {RESET_BG, RESET_FG, BLANK_CHAR};

	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cur_pos_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} cell_wr_t;

	typedef struct packed {
		logic              commit;
		logic              home;
		logic [CHAR_W-1:0] char_code;
	} cur_cmd_t;

	typedef struct packed {
		cur_pos_t pos;
		cur_pos_t nxt;
		cell_wr_t wr;
		logic     scroll;
	} cur_stat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input cur_pos_t p);
		return ADDR_W'(p.row) * ADDR_W'(COLUMNS) + ADDR_W'(p.col);
	endfunction

endpackage

// ===== hw/rtl/tmcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/tmcw_cursor.sv =====
// Cursor registers and the per-character step: control codes, cell write,
// column wrap and scroll request. Depends on tmcw_pkg.
module tmcw_cursor
	import tmcw_pkg::*;
#(
	parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cur_cmd_t          cmd,
	input  logic [CHAR_W-1:0] attr,
	output cur_stat_t         stat
);

	localparam int PH_W   = $clog2(TAB_WIDTH);
	localparam int CSUM_W = $clog2(COLUMNS + TAB_WIDTH);
	localparam int RSUM_W = $clog2(ROWS + 1);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	// column modulo the tab width, tracked alongside the column
	logic [PH_W-1:0]   phase_q;

	logic [COL_W-1:0]  col_sel;
	logic [PH_W-1:0]   ph_n;
	logic [CSUM_W-1:0] col_w;
	logic [RSUM_W-1:0] row_w;
	cur_pos_t          pos;
	cur_pos_t          wr_pos;
	logic              scroll;
	logic              wr_we;
	logic [CELL_W-1:0] wr_data;

	assign pos.col = col_q;
	assign pos.row = row_q;

	always_comb begin
		col_sel = col_q;
		ph_n    = phase_q;
		col_w   = CSUM_W'(col_q);
		row_w   = RSUM_W'(row_q);
		wr_we   = 1'b0;
		wr_data = {attr, cmd.char_code};
		unique case (cmd.char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_sel = col_q - 1'b1;
					ph_n    = (phase_q == '0) ? PH_W'(TAB_WIDTH - 1) : phase_q - 1'b1;
				end
				col_w   = CSUM_W'(col_sel);
				wr_we   = 1'b1;
				wr_data = {attr, BLANK_CHAR};
			end
			CH_TAB: begin
				col_w = CSUM_W'(col_q) + CSUM_W'(TAB_WIDTH) - CSUM_W'(phase_q);
				ph_n  = '0;
			end
			CH_LF: begin
				col_w = '0;
				row_w = RSUM_W'(row_q) + 1'b1;
				ph_n  = '0;
			end
			CH_CR: begin
				col_w = '0;
				ph_n  = '0;
			end
			default: begin
				wr_we = 1'b1;
				col_w = CSUM_W'(col_q) + 1'b1;
				ph_n  = (phase_q == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_q + 1'b1;
			end
		endcase
		if (col_w >= CSUM_W'(COLUMNS)) begin
			col_w = '0;
			row_w = row_w + 1'b1;
			ph_n  = '0;
		end
		scroll = (row_w >= RSUM_W'(ROWS));
		if (scroll) begin
			row_w = RSUM_W'(ROWS - 1);
		end
	end

	assign wr_pos.row   = row_q;
	assign wr_pos.col   = col_sel;
	assign stat.wr.we   = wr_we;
	assign stat.wr.data = wr_data;
	assign stat.wr.addr = cell_addr(wr_pos);
	assign stat.pos     = pos;
	assign stat.nxt.col = COL_W'(col_w);
	assign stat.nxt.row = ROW_W'(row_w);
	assign stat.scroll  = scroll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (cmd.home) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (cmd.commit) begin
			col_q   <= stat.nxt.col;
			row_q   <= stat.nxt.row;
			phase_q <= ph_n;
		end
	end

endmodule

// ===== hw/rtl/tmcw_seq.sv =====
// Item sequencer: input handshake, screen RAM port control, fill and scroll
// sweeps, read return and the output register. Depends on tmcw_pkg.
module tmcw_seq
	import tmcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ADDR_W-1:0] cell_index,
	input  logic [CHAR_W-1:0] attr,
	input  cur_stat_t         cur,
	output cur_cmd_t          cmd,
	output cell_wr_t          ram_wr,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [CELL_W-1:0] ram_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output cur_pos_t          out_pos,
	output logic [ADDR_W-1:0] out_index,
	output logic [CELL_W-1:0] out_value
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	localparam logic [1:0] MODE_INIT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_SCROLL = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [CELL_W-1:0] fill_q;
	logic              hit_q;
	logic              wv_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic              copy_s1;
	logic              out_valid_q;
	cur_pos_t          out_pos_q;
	logic [CELL_W-1:0] out_value_q;

	logic              accept;
	logic              hit;
	logic              copy;
	logic              start;
	logic [1:0]        start_mode;
	logic              load;
	cur_pos_t          load_pos;
	logic [CELL_W-1:0] load_val;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign hit      = (cell_index < ADDR_W'(CELL_COUNT));
	assign copy     = (mode_q == MODE_SCROLL) && (cnt_q < ADDR_W'(CELL_COUNT - COLUMNS));

	assign cmd.commit    = accept && (action == ACT_WRITE);
	assign cmd.home      = accept && (action == ACT_CLEAR);
	assign cmd.char_code = char_code;

	// scroll reads one row ahead of the write that lands in the next cycle
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if ((state_q == ST_SWEEP) && copy) begin
			ram_re    = 1'b1;
			ram_raddr = cnt_q + ADDR_W'(COLUMNS);
		end else if (accept && (action == ACT_READ) && hit) begin
			ram_re    = 1'b1;
			ram_raddr = cell_index;
		end
	end

	always_comb begin
		if (wv_s1) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = waddr_s1;
			ram_wr.data = copy_s1 ? ram_rdata : fill_q;
		end else begin
			ram_wr.we   = cmd.commit && cur.wr.we;
			ram_wr.addr = cur.wr.addr;
			ram_wr.data = cur.wr.data;
		end
	end

	always_comb begin
		state_d    = state_q;
		start      = 1'b0;
		start_mode = MODE_CLEAR;
		load       = 1'b0;
		load_pos   = cur.pos;
		load_val   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_WRITE: begin
							if (cur.scroll) begin
								start      = 1'b1;
								start_mode = MODE_SCROLL;
							end else begin
								load     = 1'b1;
								load_pos = cur.nxt;
							end
						end
						ACT_CLEAR: begin
							start      = 1'b1;
							start_mode = MODE_CLEAR;
						end
						ACT_READ: begin
							state_d = ST_READ;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
				if (start) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
				load    = (mode_q != MODE_INIT);
			end
			ST_READ: begin
				state_d  = ST_IDLE;
				load     = 1'b1;
				load_val = hit_q ? ram_rdata : '0;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			mode_q      <= MODE_INIT;
			cnt_q       <= '0;
			fill_q      <= RESET_CELL;
			hit_q       <= 1'b0;
			wv_s1       <= 1'b0;
			waddr_s1    <= '0;
			copy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wv_s1    <= (state_q == ST_SWEEP);
			waddr_s1 <= cnt_q;
			copy_s1  <= copy;
			if (start) begin
				mode_q <= start_mode;
				fill_q <= {attr, BLANK_CHAR};
				cnt_q  <= '0;
			end else if (state_q == ST_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				hit_q <= hit;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pos_q   <= load_pos;
			out_value_q <= load_val;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos   = out_pos_q;
	assign out_index = cell_addr(out_pos_q);
	assign out_value = out_value_q;

endmodule

// ===== hw/rtl/text_mode_console_writer.sv =====
// Printable, backspace, tab, CR and LF without scroll: result in the cycle after the
// beat, one item per cycle sustained while m_tready is high; read: the cell passes the
// registered RAM read port to the output register, one read at a time; clear and scroll:
// result after the one-cell-per-cycle sweep of the screen RAM, s_tready low until
// the result is loaded. Reset: asynchronous, active low; after release the screen RAM is
// filled with blank cells with s_tready low; configuration writes are taken then.
`include "text_mode_console_writer_macros.svh"

module text_mode_console_writer
	import tmcw_pkg::*;
#(
	parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// char_code [7:0], cell_index [18:8], zero pad above
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// action [1:0]
	input  logic [ACT_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// cursor_index [10:0], cursor_col [17:11], cursor_row [22:18], read_value [38:23]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic [CHAR_W-1:0]  attr;

	cur_cmd_t           cmd;
	cur_stat_t          cur;
	cell_wr_t           ram_wr;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;
	cur_pos_t           out_pos;
	logic [ADDR_W-1:0]  out_index;
	logic [CELL_W-1:0]  out_value;

	assign cfg_ready = 1'b1;
	assign attr      = {bg_q, fg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RESET_FG;
			bg_q <= RESET_BG;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FG:  fg_q <= cfg_data;
				CFG_BG:  bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tmcw_cursor #(
		.TAB_WIDTH(TAB_WIDTH)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.attr  (attr),
		.stat  (cur)
	);

	tmcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_wr.we),
		.waddr(ram_wr.addr),
		.wdata(ram_wr.data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tmcw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.action    (s_tuser),
		.char_code (s_tdata[CHAR_W-1:0]),
		.cell_index(s_tdata[CHAR_W +: ADDR_W]),
		.attr      (attr),
		.cur       (cur),
		.cmd       (cmd),
		.ram_wr    (ram_wr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pos   (out_pos),
		.out_index (out_index),
		.out_value (out_value)
	);

	assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
		out_value, out_pos.row, out_pos.col, out_index};

	`TMCW_ASSERT_NEVER(a_cursor_range, clk, arst_n, (cur.pos.col >= COL_W'(COLUMNS)) || (cur.pos.row >= ROW_W'(ROWS)), "cursor left the screen")
	`TMCW_ASSERT(a_read_stalls, clk, arst_n, s_tvalid && s_tready && (s_tuser == ACT_READ) |=> !s_tready, "read beat not followed by a stall")
	`TMCW_ASSERT(a_plain_write_result, clk, arst_n, s_tvalid && s_tready && (s_tuser == ACT_WRITE) && !cur.scroll |=> m_tvalid, "write without scroll gave no result next cycle")
	`TMCW_ASSERT_NEVER(a_no_write_in_read, clk, arst_n, (s_tvalid && s_tready && (s_tuser == ACT_READ)) && ram_wr.we, "screen written on a read beat")

endmodule
